/* sv/uerf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerf_pkg
// Types and constants shared by the echo range filter modules.
// ----------------------------------------------------------------------------
package uerf_pkg;

    localparam int ECHO_W  = 16;
    localparam int DIST_W  = 8;
    localparam int QUOT_W  = 11;
    localparam int RECIP_W = 15;
    localparam int PROD_W  = ECHO_W + RECIP_W;
    localparam int CFG_IDX_W = 8;

    // Division by 58 as multiplication by ceil(2^20 / 58); exact for 16-bit inputs.
    localparam logic [RECIP_W-1:0] CM_RECIP = RECIP_W'(18079);
    localparam int CM_SHIFT = 20;

    localparam logic [DIST_W-1:0] NEAR_RESET = DIST_W'(20);
    localparam logic [DIST_W-1:0] FAR_RESET  = DIST_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT      = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        POS_FIRST  = 2'd0,
        POS_SECOND = 2'd1,
        POS_THIRD  = 2'd2
    } sample_pos_t;

    typedef struct packed {
        logic [ECHO_W-1:0] a;
        logic [ECHO_W-1:0] b;
        logic [ECHO_W-1:0] c;
    } triple_t;

    typedef struct packed {
        logic [DIST_W-1:0] near_threshold;
        logic [DIST_W-1:0] far_limit;
    } cfg_t;

endpackage

/* sv/uerf_group.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerf_group
// Collects echo samples into groups of three and registers each full group.
// ----------------------------------------------------------------------------
module uerf_group import uerf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ECHO_W-1:0] s_echo_time_us,
    output logic              grp_valid,
    input  logic              grp_ready,
    output triple_t           grp_data
);

    sample_pos_t       pos_reg, pos_next;
    logic [ECHO_W-1:0] first_reg, first_next;
    logic [ECHO_W-1:0] second_reg, second_next;
    logic              valid_reg, valid_next;
    triple_t           data_reg, data_next;
    logic              accept;

    assign s_ready = !valid_reg || grp_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        data_next   = data_reg;
        valid_next  = valid_reg && !grp_ready;
        if (accept) begin
            case (pos_reg)
                POS_FIRST: begin
                    first_next = s_echo_time_us;
                    pos_next   = POS_SECOND;
                end
                POS_SECOND: begin
                    second_next = s_echo_time_us;
                    pos_next    = POS_THIRD;
                end
                default: begin
                    data_next.a = first_reg;
                    data_next.b = second_reg;
                    data_next.c = s_echo_time_us;
                    valid_next  = 1'b1;
                    pos_next    = POS_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= POS_FIRST;
            first_reg  <= '0;
            second_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            valid_reg  <= valid_next;
        end
        data_reg <= data_next;
    end

    assign grp_valid = valid_reg;
    assign grp_data  = data_reg;

endmodule

/* sv/uerf_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerf_select
// Picks the representative sample of a group and registers it.
// ----------------------------------------------------------------------------
module uerf_select import uerf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  triple_t           in_data,
    output logic              sel_valid,
    input  logic              sel_ready,
    output logic [ECHO_W-1:0] sel_data
);

    logic              valid_reg, valid_next;
    logic [ECHO_W-1:0] sel_reg, sel_next;
    logic [ECHO_W-1:0] diff_ab, diff_ac, diff_bc;

    assign in_ready = !valid_reg || sel_ready;

    always_comb begin
        diff_ab = (in_data.a > in_data.b) ? in_data.a - in_data.b : in_data.b - in_data.a;
        diff_ac = (in_data.a > in_data.c) ? in_data.a - in_data.c : in_data.c - in_data.a;
        diff_bc = (in_data.b > in_data.c) ? in_data.b - in_data.c : in_data.c - in_data.b;
        sel_next   = sel_reg;
        valid_next = valid_reg && !sel_ready;
        if (in_valid && in_ready) begin
            sel_next   = (diff_ab < diff_bc || diff_ac < diff_bc) ? in_data.a : in_data.b;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        sel_reg <= sel_next;
    end

    assign sel_valid = valid_reg;
    assign sel_data  = sel_reg;

endmodule

/* sv/uerf_divide.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerf_divide
// Converts the selected echo time to centimetres by a reciprocal multiply.
// ----------------------------------------------------------------------------
module uerf_divide import uerf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ECHO_W-1:0] in_data,
    output logic              quot_valid,
    input  logic              quot_ready,
    output logic [QUOT_W-1:0] quot_data
);

    logic              valid_reg, valid_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [PROD_W-1:0] product;

    assign in_ready = !valid_reg || quot_ready;
    assign product  = PROD_W'(in_data) * PROD_W'(CM_RECIP);

    always_comb begin
        quot_next  = quot_reg;
        valid_next = valid_reg && !quot_ready;
        if (in_valid && in_ready) begin
            quot_next  = product[CM_SHIFT +: QUOT_W];
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        quot_reg <= quot_next;
    end

    assign quot_valid = valid_reg;
    assign quot_data  = quot_reg;

endmodule

/* sv/uerf_range.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerf_range
// Range check, LED decision and repeat suppression, with the result register.
// ----------------------------------------------------------------------------
module uerf_range import uerf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [QUOT_W-1:0] in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DIST_W-1:0] m_distance_cm,
    output logic              m_led_on,
    output logic              m_publish
);

    logic              valid_reg, valid_next;
    logic              tx_en_reg, tx_en_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic              led_reg, led_next;
    logic              pub_reg, pub_next;
    logic              out_of_range;

    assign in_ready     = !valid_reg || m_ready;
    assign out_of_range = (in_data == '0) || (in_data > QUOT_W'(cfg.far_limit));

    always_comb begin
        dist_next  = dist_reg;
        led_next   = led_reg;
        pub_next   = pub_reg;
        tx_en_next = tx_en_reg;
        valid_next = valid_reg && !m_ready;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            if (out_of_range) begin
                dist_next  = cfg.far_limit;
                led_next   = 1'b0;
                pub_next   = tx_en_reg;
                tx_en_next = 1'b0;
            end else begin
                dist_next  = in_data[DIST_W-1:0];
                led_next   = (in_data < QUOT_W'(cfg.near_threshold));
                pub_next   = 1'b1;
                tx_en_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tx_en_reg <= 1'b1;
        end else begin
            valid_reg <= valid_next;
            tx_en_reg <= tx_en_next;
        end
        dist_reg <= dist_next;
        led_reg  <= led_next;
        pub_reg  <= pub_next;
    end

    assign m_valid       = valid_reg;
    assign m_distance_cm = dist_reg;
    assign m_led_on      = led_reg;
    assign m_publish     = pub_reg;

endmodule

/* sv/ultrasonic_echo_range_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_filter
// Groups echo times in threes, selects one, converts it to centimetres and
// range checks it, giving one distance result per group.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      s_echo_time_us[15:0]
//   m_        out        m_valid / m_ready      m_distance_cm[7:0], m_led_on,
//                                               m_publish
//   cfg_      in         cfg_valid / cfg_ready  cfg_index[7:0], cfg_data[7:0]
//
// One sample request is taken per cycle while s_ready is high; the pipeline
// is a group register, a selection stage, a multiply stage and the result
// register, through which each group's result passes in that order.
// Reset clears the group position, all stage valids and the suppression
// flag, and restores the register defaults. A stall on m_ready holds every
// filled stage in place and backs up to s_ready. Configuration is always ready.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_filter import uerf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ECHO_W-1:0]    s_echo_time_us,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DIST_W-1:0]    m_distance_cm,
    output logic                 m_led_on,
    output logic                 m_publish,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    cfg_t              cfg_reg, cfg_next;
    logic              grp_valid, grp_ready;
    triple_t           grp_data;
    logic              sel_valid, sel_ready;
    logic [ECHO_W-1:0] sel_data;
    logic              quot_valid, quot_ready;
    logic [QUOT_W-1:0] quot_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_NEAR_THRESHOLD: cfg_next.near_threshold = cfg_data;
                CFG_FAR_LIMIT:      cfg_next.far_limit      = cfg_data;
                default:            cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_threshold <= NEAR_RESET;
            cfg_reg.far_limit      <= FAR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    uerf_group u_group (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_echo_time_us (s_echo_time_us),
        .grp_valid      (grp_valid),
        .grp_ready      (grp_ready),
        .grp_data       (grp_data)
    );

    uerf_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (grp_valid),
        .in_ready  (grp_ready),
        .in_data   (grp_data),
        .sel_valid (sel_valid),
        .sel_ready (sel_ready),
        .sel_data  (sel_data)
    );

    uerf_divide u_divide (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (sel_valid),
        .in_ready   (sel_ready),
        .in_data    (sel_data),
        .quot_valid (quot_valid),
        .quot_ready (quot_ready),
        .quot_data  (quot_data)
    );

    uerf_range u_range (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (quot_valid),
        .in_ready      (quot_ready),
        .in_data       (quot_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance_cm (m_distance_cm),
        .m_led_on      (m_led_on),
        .m_publish     (m_publish)
    );

endmodule

/* tb/tb_ultrasonic_echo_range_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_range_filter
// Self-checking bench for the echo range filter. Echo times are sent in
// groups of three, first as a short directed set and then at random across
// several register settings, with random stalls on both channels. A
// scoreboard predicts each group's distance, LED and publish flag from its
// own copy of the state and the registers, and compares every result
// request in order.
// ----------------------------------------------------------------------------
module tb_ultrasonic_echo_range_filter;
    import uerf_pkg::*;

    localparam int US_PER_CM = 58;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic              led_on;
        logic              publish;
    } range_result_t;

    class echo_range_scoreboard;
        logic [DIST_W-1:0] near_cm = NEAR_RESET;
        logic [DIST_W-1:0] far_cm = FAR_RESET;
        sample_pos_t       pos = POS_FIRST;
        logic [ECHO_W-1:0] first_us = '0;
        logic [ECHO_W-1:0] second_us = '0;
        bit                tx_enabled = 1'b1;
        range_result_t     expected_q[$];
        int unsigned       mismatches = 0;

        function automatic logic [ECHO_W-1:0] gap(logic [ECHO_W-1:0] x, logic [ECHO_W-1:0] y);
            return (x > y) ? x - y : y - x;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
            if (idx == CFG_NEAR_THRESHOLD) begin
                near_cm = data;
            end else if (idx == CFG_FAR_LIMIT) begin
                far_cm = data;
            end
        endfunction

        function void note_sample(logic [ECHO_W-1:0] us);
            logic [ECHO_W-1:0] bc;
            logic [ECHO_W-1:0] sel;
            logic [10:0]       cm;
            range_result_t     r;
            case (pos)
                POS_FIRST: begin
                    first_us = us;
                    pos = POS_SECOND;
                end
                POS_SECOND: begin
                    second_us = us;
                    pos = POS_THIRD;
                end
                default: begin
                    pos = POS_FIRST;
                    bc = gap(second_us, us);
                    sel = (gap(first_us, second_us) < bc || gap(first_us, us) < bc) ?
                          first_us : second_us;
                    cm = 11'(int'(sel) / US_PER_CM);
                    if (cm == 0 || cm > far_cm) begin
                        r.distance_cm = far_cm;
                        r.led_on = 1'b0;
                        r.publish = tx_enabled;
                        tx_enabled = 1'b0;
                    end else begin
                        r.distance_cm = cm[DIST_W-1:0];
                        r.led_on = (cm < near_cm);
                        r.publish = 1'b1;
                        tx_enabled = 1'b1;
                    end
                    expected_q.push_back(r);
                end
            endcase
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endfunction

        function void check_result(logic [DIST_W-1:0] d, logic l, logic p);
            range_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result dist %0d led %b pub %b", d, l, p));
            end else begin
                e = expected_q.pop_front();
                if (d !== e.distance_cm || l !== e.led_on || p !== e.publish) begin
                    report($sformatf("expected dist %0d led %b pub %b, got dist %0d led %b pub %b",
                                     e.distance_cm, e.led_on, e.publish, d, l, p));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [ECHO_W-1:0]    s_echo_time_us;
    logic                 m_valid;
    logic                 m_ready;
    logic [DIST_W-1:0]    m_distance_cm;
    logic                 m_led_on;
    logic                 m_publish;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;

    echo_range_scoreboard sb = new;
    bit calm = 1'b0;

    ultrasonic_echo_range_filter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_echo_time_us (s_echo_time_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance_cm  (m_distance_cm),
        .m_led_on       (m_led_on),
        .m_publish      (m_publish),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_distance_cm, m_led_on, m_publish);
        end
    end

    task automatic send_sample(input logic [ECHO_W-1:0] us);
        s_valid <= 1'b1;
        s_echo_time_us <= us;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(us);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int n_items, input int idle_pct);
        int count;
        int style;
        int span;
        int v;
        int k;
        int odd_one;
        logic [ECHO_W-1:0] base;
        logic [ECHO_W-1:0] trio[3];
        count = 0;
        while (count < n_items) begin
            style = $urandom_range(0, 9);
            span = (int'(sb.far_cm) + 3) * US_PER_CM;
            base = ECHO_W'($urandom_range(0, span));
            odd_one = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
            for (k = 0; k < 3; k++) begin
                if (style < 2 || k == odd_one) begin
                    trio[k] = ECHO_W'($urandom);
                end else if (style < 4) begin
                    trio[k] = ECHO_W'($urandom_range(0, 130));
                end else if (style == 4) begin
                    trio[k] = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    v = int'(base) + int'($urandom_range(0, 400)) - 200;
                    if (v < 0) begin
                        v = 0;
                    end else if (v > 65535) begin
                        v = 65535;
                    end
                    trio[k] = ECHO_W'(v);
                end
            end
            for (k = 0; k < 3; k++) begin
                send_sample(trio[k]);
                count++;
                if (!calm && $urandom_range(0, 99) < idle_pct) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end
            end
        end
    endtask

    task automatic run_setting(input logic [DIST_W-1:0] near, input logic [DIST_W-1:0] far,
                               input int n_items, input int idle_pct);
        drain();
        program_reg(CFG_IDX_W'($urandom_range(int'(CFG_FAR_LIMIT) + 1, 254)),
                    DIST_W'($urandom));
        program_reg(CFG_NEAR_THRESHOLD, near);
        program_reg(CFG_FAR_LIMIT, far);
        program_reg('1, DIST_W'($urandom));
        cfg_valid <= 1'b0;
        run_phase(n_items, idle_pct);
    endtask

    initial begin
        logic [ECHO_W-1:0] directed[24];
        int i;
        directed = '{16'd0, 16'd0, 16'd0,
                     16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'd580, 16'd1000, 16'd5000,
                     16'd3000, 16'd1200, 16'd1210,
                     16'd5800, 16'd5800, 16'd6000,
                     16'd5858, 16'd0, 16'hFFFF,
                     16'd57, 16'd57, 16'd57,
                     16'd2320, 16'd0, 16'd2000};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_echo_time_us = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 24; i++) begin
            send_sample(directed[i]);
        end

        run_setting(8'd0, 8'd255, 250, 30);
        run_setting(8'd255, 8'd1, 250, 0);
        run_setting(8'd255, 8'd0, 250, 30);
        run_setting(8'd200, 8'd50, 250, 40);
        run_setting(DIST_W'($urandom), DIST_W'($urandom_range(1, 255)), 250, 20);
        run_setting(DIST_W'($urandom), DIST_W'($urandom_range(1, 255)), 250, 30);
        calm = 1'b1;
        run_setting(NEAR_RESET, FAR_RESET, 250, 0);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* ultrasonic_echo_range_filter.f */
sv/uerf_pkg.sv
sv/uerf_group.sv
sv/uerf_select.sv
sv/uerf_divide.sv
sv/uerf_range.sv
sv/ultrasonic_echo_range_filter.sv
tb/tb_ultrasonic_echo_range_filter.sv
